// File: rtl/fta_pkg.sv
package fta_pkg;

  localparam int NumFansDefault = 5;
  localparam int ActiveFansReset = 3;

  localparam int IdxW = 3;
  localparam int CountW = 8;
  localparam int ExpW = 3;
  localparam int SpeedW = 21;
  localparam int DivisorW = CountW + (1 << ExpW) - 1;
  localparam int RemW = DivisorW + 1;

  localparam int InDataW = 16;
  localparam int OutDataW = 32;

  localparam logic [SpeedW-1:0] SpeedNumerator = SpeedW'(1350000);
  localparam logic [CountW-1:0] StallCount = 8'hff;
  localparam logic [CountW-1:0] RaiseAbove = 8'd192;
  localparam logic [CountW-1:0] LowerBelow = 8'd96;
  localparam logic [ExpW-1:0] ExpMax = 3'd7;

  localparam int DivSteps = SpeedW;
  localparam int StepW = $clog2(DivSteps);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } fta_state_t;

endpackage

// File: rtl/fan_tach_autorange.sv
// Fan speed from an 8-bit tachometer count: speed_rpm = floor(1350000 / (count << e)),
// where e is a 3-bit divisor exponent kept per fan. After each beat the exponent adapts
// with hysteresis: up by one above a count of 192, down by one below 96. A count of 255
// reads as a stopped fan (speed 0), a count of 0 saturates to 1350000 and sets
// zero_count_flag, and a fan index at or above active_fans (or NUM_FANS) is answered
// with index_ignored and leaves the state alone. One item is in flight at a time:
// in_tready is high only while idle. A normal count goes through a restoring divider
// that retires one quotient bit per cycle; an item passes through a load, the divide
// steps and a result beat that waits for out_tready before the next accept;
// stalled, zero-count and ignored items skip the divider and its steps.
// active_fans is written through cfg_wen/cfg_wdata and resets to 3.
module fan_tach_autorange
  import fta_pkg::*;
#(
  parameter int NUM_FANS = NumFansDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wen,
  input  logic [2:0]          cfg_wdata,   // active_fans
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,    // fan_index[2:0], tach_count[10:3], zero pad
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata    // speed_rpm[20:0], new_exponent[23:21],
                                           // divisor_changed[24], zero_count_flag[25],
                                           // index_ignored[26], zero pad
);

  localparam int SlotW = (NUM_FANS > 1) ? $clog2(NUM_FANS) : 1;

  fta_state_t state_r, state_nxt;

  logic [2:0]          active_fans_r;
  logic [ExpW-1:0]     exp_r [NUM_FANS];
  logic [SpeedW-1:0]   num_r;
  logic [RemW-1:0]     rem_r;
  logic [DivisorW-1:0] div_r;
  logic [StepW-1:0]    step_r;
  logic [ExpW-1:0]     new_exp_r;
  logic                changed_r;
  logic                zero_r;
  logic                ign_r;

  logic [IdxW-1:0]     fan_index;
  logic [CountW-1:0]   tach_count;
  logic                in_beat;
  logic                ignored;
  logic [ExpW-1:0]     exp_old;
  logic [ExpW-1:0]     exp_new;
  logic [RemW-1:0]     trial;
  logic                qbit;
  logic                last_step;

  assign fan_index  = in_tdata[IdxW-1:0];
  assign tach_count = in_tdata[IdxW +: CountW];
  assign in_beat    = in_tvalid && in_tready;

  assign ignored = (fan_index >= active_fans_r) ||
                   ({1'b0, fan_index} >= (IdxW+1)'(NUM_FANS));

  // exponent lookup as an equality mux on the low index bits; indices that match no fan read zero
  always_comb begin
    exp_old = '0;
    for (int i = 0; i < NUM_FANS; i++) begin
      if (fan_index[SlotW-1:0] == SlotW'(i)) begin
        exp_old = exp_r[i];
      end
    end
  end

  always_comb begin
    exp_new = exp_old;
    if (tach_count > RaiseAbove && exp_old < ExpMax) begin
      exp_new = exp_old + 1'b1;
    end else if (tach_count < LowerBelow && exp_old != '0) begin
      exp_new = exp_old - 1'b1;
    end
  end

  // one restoring step: bring in the next dividend bit, subtract if it fits
  assign trial     = {rem_r[RemW-2:0], num_r[SpeedW-1]};
  assign qbit      = (trial >= {1'b0, div_r});
  assign last_step = (step_r == StepW'(DivSteps - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (ignored || tach_count == StallCount || tach_count == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (last_step) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_fans_r <= 3'(ActiveFansReset);
      for (int i = 0; i < NUM_FANS; i++) begin
        exp_r[i] <= '0;
      end
    end else begin
      if (cfg_wen) begin
        active_fans_r <= cfg_wdata;
      end
      if (in_beat && !ignored) begin
        for (int i = 0; i < NUM_FANS; i++) begin
          if (fan_index[SlotW-1:0] == SlotW'(i)) begin
            exp_r[i] <= exp_new;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (in_beat) begin
      step_r <= '0;
    end else if (state_r == ST_DIV) begin
      step_r <= step_r + 1'b1;
    end
  end

  // num_r holds the dividend on load and shifts the quotient in from the bottom
  always_ff @(posedge clk) begin
    if (in_beat) begin
      rem_r     <= '0;
      div_r     <= DivisorW'(tach_count) << exp_old;
      ign_r     <= ignored;
      zero_r    <= !ignored && (tach_count == '0);
      new_exp_r <= ignored ? '0 : exp_new;
      changed_r <= !ignored && (exp_new != exp_old);
      if (ignored || tach_count == StallCount) begin
        num_r <= '0;
      end else begin
        num_r <= SpeedNumerator;
      end
    end else if (state_r == ST_DIV) begin
      rem_r <= qbit ? (trial - {1'b0, div_r}) : trial;
      num_r <= {num_r[SpeedW-2:0], qbit};
    end
  end

  assign out_tdata = {{(OutDataW - SpeedW - ExpW - 3){1'b0}},
                      ign_r, zero_r, changed_r, new_exp_r, num_r};

`ifndef SYNTH
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and result sides open together");

  a_ignored_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[26] |-> out_tdata[25:0] == '0)
    else $error("ignored beat carries nonzero result");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> step_r < StepW'(DivSteps))
    else $error("divider ran past its step count");

  a_exp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_beat |=> $stable(exp_r[0]))
    else $error("exponent changed without an input beat");
`endif

endmodule
